// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions that are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle whenever a trigger is seen.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rmwq_pkg.sv -----
// ----------------------------------------------------------------------------
// Recursive mutex wait queue package
// Request and response types, status codes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmwq_pkg;

	// Default sizes for the top-level parameters.
	localparam int WAITER_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF      = 8;
	localparam int DEPTH_BITS_DEF   = 16;

	// Fixed field widths of the request and response.
	localparam int ID_W      = 8;
	localparam int STATUS_W  = 4;
	localparam int DEPTH_W   = 16;
	localparam int WAITERS_W = 5;

	// Request commands.
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_GRANTED    = 4'd0;
	localparam logic [STATUS_W-1:0] ST_NESTED     = 4'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED     = 4'd2;
	localparam logic [STATUS_W-1:0] ST_REL_NESTED = 4'd3;
	localparam logic [STATUS_W-1:0] ST_FREED      = 4'd4;
	localparam logic [STATUS_W-1:0] ST_HANDED     = 4'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 4'd6;
	localparam logic [STATUS_W-1:0] ST_QFULL      = 4'd7;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 4'd8;

	typedef struct packed {
		logic            command;
		logic [ID_W-1:0] requester_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 woken_valid;
		logic [ID_W-1:0]      woken_id;
		logic [ID_W-1:0]      holder_now;
		logic                 lock_held;
		logic [DEPTH_W-1:0]   depth_now;
		logic [WAITERS_W-1:0] waiters_now;
	} rsp_t;

endpackage

// ----- hdl/recursive_mutex_wait_queue_core.sv -----
// ----------------------------------------------------------------------------
// Recursive mutex with FIFO waiter queue
// Grants, nests, queues and releases a lock; a final release hands the lock
// straight to the oldest waiter.
// ----------------------------------------------------------------------------
//   channel | ports                       | moves
//   --------+-----------------------------+------------------------------------
//   request | req_valid, req_ready, req   | acquire or release from an ID
//   reply   | rsp_valid, rsp_ready, rsp   | status and lock state after it
//
// Each request is decided combinationally and its reply is registered, so one
// request per cycle is taken while the skid entry is empty.
// The waiter store has one write port at the tail and one registered read of
// the next head, which keeps the oldest waiter ready for hand-over.
// A two-entry reply buffer (output register plus skid) keeps req_ready free of
// rsp_ready. Reset frees the lock and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module recursive_mutex_wait_queue_core #(
	parameter int WAITER_DEPTH = rmwq_pkg::WAITER_DEPTH_DEF,
	parameter int ID_BITS      = rmwq_pkg::ID_BITS_DEF,
	parameter int DEPTH_BITS   = rmwq_pkg::DEPTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rmwq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rmwq_pkg::rsp_t rsp
);

	localparam int AW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
	localparam int FW = $clog2(WAITER_DEPTH + 1);
	localparam int IW = rmwq_pkg::ID_W;
	localparam int DW = rmwq_pkg::DEPTH_W;
	localparam int WW = rmwq_pkg::WAITERS_W;

	// Lock state.
	logic                  held_q;
	logic [ID_BITS-1:0]    holder_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [FW-1:0]         fill_q;

	// Waiter store and the registered copy of the entry at the head.
	logic [ID_BITS-1:0]    waiters_mem [WAITER_DEPTH];
	logic [ID_BITS-1:0]    head_data_q;

	// Reply buffer.
	logic                  out_valid_q;
	rmwq_pkg::rsp_t        out_q;
	logic                  skid_valid_q;
	rmwq_pkg::rsp_t        skid_q;

	logic                  push;
	logic                  pop;
	logic [ID_BITS-1:0]    who;
	logic [ID_BITS+IW-1:0] who_ext;
	logic                  nxt_held;
	logic [ID_BITS-1:0]    nxt_holder;
	logic [DEPTH_BITS-1:0] nxt_depth;
	logic [AW-1:0]         nxt_head;
	logic [AW-1:0]         nxt_tail;
	logic [FW-1:0]         nxt_fill;
	logic                  wr_en;
	logic [AW-1:0]         rd_addr;
	logic [rmwq_pkg::STATUS_W-1:0] status;
	logic                  woken_valid;
	logic [ID_BITS-1:0]    woken_id;
	logic [ID_BITS+IW-1:0] woken_ext;
	logic [ID_BITS+IW-1:0] holder_ext;
	logic [DEPTH_BITS+DW-1:0] depth_ext;
	logic [FW+WW-1:0]      fill_ext;
	rmwq_pkg::rsp_t        rsp_new;

	assign push      = req_valid && req_ready;
	assign pop       = out_valid_q && rsp_ready;
	assign req_ready = !skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Bring the requester ID to the internal width.
	assign who_ext = {{ID_BITS{1'b0}}, req.requester_id};
	assign who     = who_ext[ID_BITS-1:0];

	// Decide the request and the next lock state.
	always_comb begin
		nxt_held    = held_q;
		nxt_holder  = holder_q;
		nxt_depth   = depth_q;
		nxt_head    = head_q;
		nxt_tail    = tail_q;
		nxt_fill    = fill_q;
		wr_en       = 1'b0;
		woken_valid = 1'b0;
		woken_id    = '0;
		status      = rmwq_pkg::ST_NOT_HOLDER;
		if (req.command == rmwq_pkg::CMD_ACQUIRE) begin
			if (!held_q) begin
				nxt_held   = 1'b1;
				nxt_holder = who;
				nxt_depth  = DEPTH_BITS'(1);
				status     = rmwq_pkg::ST_GRANTED;
			end else if (holder_q == who) begin
				if (depth_q == {DEPTH_BITS{1'b1}}) begin
					status = rmwq_pkg::ST_OVERFLOW;
				end else begin
					nxt_depth = depth_q + DEPTH_BITS'(1);
					status    = rmwq_pkg::ST_NESTED;
				end
			end else if (fill_q == FW'(WAITER_DEPTH)) begin
				status = rmwq_pkg::ST_QFULL;
			end else begin
				wr_en    = 1'b1;
				nxt_tail = (tail_q == AW'(WAITER_DEPTH - 1)) ? '0 : tail_q + AW'(1);
				nxt_fill = fill_q + FW'(1);
				status   = rmwq_pkg::ST_QUEUED;
			end
		end else begin
			if (!held_q || holder_q != who) begin
				status = rmwq_pkg::ST_NOT_HOLDER;
			end else if (depth_q > DEPTH_BITS'(1)) begin
				nxt_depth = depth_q - DEPTH_BITS'(1);
				status    = rmwq_pkg::ST_REL_NESTED;
			end else if (fill_q != '0) begin
				woken_valid = 1'b1;
				woken_id    = head_data_q;
				nxt_holder  = head_data_q;
				nxt_depth   = DEPTH_BITS'(1);
				nxt_head    = (head_q == AW'(WAITER_DEPTH - 1)) ? '0 : head_q + AW'(1);
				nxt_fill    = fill_q - FW'(1);
				status      = rmwq_pkg::ST_HANDED;
			end else begin
				nxt_held   = 1'b0;
				nxt_holder = '0;
				nxt_depth  = '0;
				status     = rmwq_pkg::ST_FREED;
			end
		end
	end

	// Fit internal widths to the reply fields.
	assign woken_ext  = {{IW{1'b0}}, woken_id};
	assign holder_ext = {{IW{1'b0}}, nxt_holder};
	assign depth_ext  = {{DW{1'b0}}, nxt_depth};
	assign fill_ext   = {{WW{1'b0}}, nxt_fill};

	always_comb begin
		rsp_new.status      = status;
		rsp_new.woken_valid = woken_valid;
		rsp_new.woken_id    = woken_ext[IW-1:0];
		rsp_new.holder_now  = holder_ext[IW-1:0];
		rsp_new.lock_held   = nxt_held;
		rsp_new.depth_now   = depth_ext[DW-1:0];
		rsp_new.waiters_now = fill_ext[WW-1:0];
	end

	// Lock state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			holder_q <= '0;
			depth_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
		end else if (push) begin
			held_q   <= nxt_held;
			holder_q <= nxt_holder;
			depth_q  <= nxt_depth;
			head_q   <= nxt_head;
			tail_q   <= nxt_tail;
			fill_q   <= nxt_fill;
		end
	end

	// Waiter store: write at the tail, read the next head with write forwarding.
	assign rd_addr = push ? nxt_head : head_q;

	always_ff @(posedge clk) begin
		if (push && wr_en) begin
			waiters_mem[tail_q] <= who;
		end
		if (push && wr_en && tail_q == rd_addr) begin
			head_data_q <= who;
		end else begin
			head_data_q <= waiters_mem[rd_addr];
		end
	end

	// Reply buffer: output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= rsp_new;
			end
		end else if (push) begin
			skid_q <= rsp_new;
		end
	end

	// Checks on the lock state and the reply buffer.
	`ASSERT_ALWAYS(a_fill_bound, fill_q <= FW'(WAITER_DEPTH), "waiter count beyond capacity")
	`ASSERT_IMPLIES(a_free_clean, !held_q, depth_q == '0 && fill_q == '0, "free lock not clean")
	`ASSERT_IMPLIES(a_held_depth, held_q, depth_q != '0, "held lock with zero depth")
	`ASSERT_IMPLIES(a_skid_order, skid_valid_q, out_valid_q, "skid entry without output entry")

endmodule

// ----- bench/recursive_mutex_wait_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// Recursive mutex wait queue testbench
// Drives acquire and release requests through the valid/ready request channel
// while the reply channel stalls on a rolling pattern. A lock tracker mirrors
// holder, depth and waiter queue, works out each reply as its request is
// taken, and compares every reply against it, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module recursive_mutex_wait_queue_core_tb;

	localparam int QUEUE_SLOTS = rmwq_pkg::WAITER_DEPTH_DEF;
	localparam int NEST_RUN = 8;
	localparam bit [rmwq_pkg::DEPTH_W-1:0] DEPTH_ONE = {{(rmwq_pkg::DEPTH_W-1){1'b0}}, 1'b1};

	// Mirror of the lock, with the replies that are still due from the block.
	class lock_tracker;
		bit                            held;
		bit [rmwq_pkg::ID_W-1:0]       holder;
		bit [rmwq_pkg::DEPTH_W-1:0]    depth;
		bit [rmwq_pkg::ID_W-1:0]       waiters [QUEUE_SLOTS];
		bit [3:0]                      head;
		bit [3:0]                      tail;
		bit [rmwq_pkg::WAITERS_W-1:0]  fill;
		rmwq_pkg::rsp_t                due_replies [$];
		int                            failures;

		function int pending();
			return due_replies.size();
		endfunction

		// Applies one accepted request to the mirror and queues its reply.
		function void note_request(rmwq_pkg::req_t r);
			rmwq_pkg::rsp_t          e;
			bit [rmwq_pkg::ID_W-1:0] who;
			who = r.requester_id;
			e = '0;
			if (r.command == rmwq_pkg::CMD_ACQUIRE) begin
				if (!held) begin
					held = 1'b1;
					holder = who;
					depth = DEPTH_ONE;
					e.status = rmwq_pkg::ST_GRANTED;
				end else if (holder == who) begin
					if (depth == '1) begin
						e.status = rmwq_pkg::ST_OVERFLOW;
					end else begin
						depth++;
						e.status = rmwq_pkg::ST_NESTED;
					end
				end else if (fill == QUEUE_SLOTS) begin
					e.status = rmwq_pkg::ST_QFULL;
				end else begin
					waiters[tail] = who;
					tail++;
					fill++;
					e.status = rmwq_pkg::ST_QUEUED;
				end
			end else begin
				if (!held || holder != who) begin
					e.status = rmwq_pkg::ST_NOT_HOLDER;
				end else if (depth > 1) begin
					depth--;
					e.status = rmwq_pkg::ST_REL_NESTED;
				end else if (fill > 0) begin
					// The oldest waiter takes the lock directly at depth one.
					e.woken_valid = 1'b1;
					e.woken_id = waiters[head];
					head++;
					fill--;
					holder = e.woken_id;
					depth = DEPTH_ONE;
					e.status = rmwq_pkg::ST_HANDED;
				end else begin
					held = 1'b0;
					holder = '0;
					depth = '0;
					e.status = rmwq_pkg::ST_FREED;
				end
			end
			e.holder_now = holder;
			e.lock_held = held;
			e.depth_now = depth;
			e.waiters_now = fill;
			due_replies.push_back(e);
		endfunction

		function void report_field(string field, int unsigned want, int unsigned got);
			failures++;
			if (failures <= 10) begin
				$display("reply mismatch on %s: expected %0d, got %0d", field, want, got);
			end
		endfunction

		// Compares one accepted reply with the oldest one still due.
		function void check_reply(rmwq_pkg::rsp_t got);
			rmwq_pkg::rsp_t e;
			if (due_replies.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("reply with no request outstanding: %p", got);
				end
				return;
			end
			e = due_replies.pop_front();
			if (got.status !== e.status)
				report_field("status", e.status, got.status);
			if (got.woken_valid !== e.woken_valid)
				report_field("woken_valid", e.woken_valid, got.woken_valid);
			if (got.woken_id !== e.woken_id)
				report_field("woken_id", e.woken_id, got.woken_id);
			if (got.holder_now !== e.holder_now)
				report_field("holder_now", e.holder_now, got.holder_now);
			if (got.lock_held !== e.lock_held)
				report_field("lock_held", e.lock_held, got.lock_held);
			if (got.depth_now !== e.depth_now)
				report_field("depth_now", e.depth_now, got.depth_now);
			if (got.waiters_now !== e.waiters_now)
				report_field("waiters_now", e.waiters_now, got.waiters_now);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rmwq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rmwq_pkg::rsp_t rsp;

	lock_tracker lock_mirror = new();
	int burst_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int pattern_age = 0;

	recursive_mutex_wait_queue_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Handshakes are observed at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				lock_mirror.note_request(req);
			if (rsp_valid && rsp_ready)
				lock_mirror.check_reply(rsp);
		end
	end

	// The reply side stalls on a rotating pattern, refreshed now and then; a
	// quarter of the patterns never stall at all.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (pattern_age == 0) begin
				if ($urandom_range(0, 3) == 0)
					ready_pattern = 16'hFFFF;
				else
					ready_pattern = 16'($urandom) | 16'h0001;
				pattern_age = $urandom_range(20, 100);
			end
			pattern_age--;
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			rsp_ready <= ready_pattern[0];
		end
	end

	// Run limit.
	initial begin
		#4_000_000;
		$display("recursive_mutex_wait_queue_core test failed");
		$finish;
	end

	// Presents one request and waits for it to be taken. Requests go out in
	// bursts of random length, with random gaps between bursts.
	task automatic issue(input logic cmd, input logic [rmwq_pkg::ID_W-1:0] id);
		rmwq_pkg::req_t r;
		int             gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(30, 80);
			else
				burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		r.command = cmd;
		r.requester_id = id;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// Holds off new requests until every reply due has come back.
	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (lock_mirror.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [rmwq_pkg::ID_W-1:0] pool [20];
		int                        pool_n;
		int                        release_pct;
		int                        roll;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: release on a free lock, grant, nesting, a stranger's
		// release, repeated waiting, hand-over to each entry in turn, free.
		issue(rmwq_pkg::CMD_RELEASE, 8'h00);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'h00);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'h00);
		issue(rmwq_pkg::CMD_RELEASE, 8'hFF);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'hFF);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'hFF);
		issue(rmwq_pkg::CMD_RELEASE, 8'h00);
		issue(rmwq_pkg::CMD_RELEASE, 8'h00);
		issue(rmwq_pkg::CMD_RELEASE, 8'hFF);
		issue(rmwq_pkg::CMD_RELEASE, 8'hFF);
		issue(rmwq_pkg::CMD_RELEASE, 8'hFF);

		// Fill the waiter queue and push one acquire past it.
		issue(rmwq_pkg::CMD_ACQUIRE, 8'hA5);
		for (int k = 0; k <= QUEUE_SLOTS; k++)
			issue(rmwq_pkg::CMD_ACQUIRE, 8'(k * 17));
		settle();

		// Random: mostly acquires from a small pool of requesters and releases
		// by the holder, with some nesting and some plain noise. Pool and
		// release rate change every so often to swing the queue between
		// empty and full.
		pool_n = 2;
		release_pct = 40;
		for (int n = 0; n < 1750; n++) begin
			if (n % 150 == 0) begin
				pool_n = $urandom_range(2, 20);
				for (int k = 0; k < 20; k++)
					pool[k] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 0)
					pool[0] = 8'h00;
				if ($urandom_range(0, 1) == 0)
					pool[1] = 8'hFF;
				case ($urandom_range(0, 2))
					0: begin
						release_pct = 20;
					end
					1: begin
						release_pct = 40;
					end
					default: begin
						release_pct = 60;
					end
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < 8)
				issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			else if (lock_mirror.held && roll < 8 + release_pct)
				issue(rmwq_pkg::CMD_RELEASE, lock_mirror.holder);
			else if (lock_mirror.held && roll < 18 + release_pct)
				issue(rmwq_pkg::CMD_ACQUIRE, lock_mirror.holder);
			else
				issue(rmwq_pkg::CMD_ACQUIRE, pool[$urandom_range(0, pool_n - 1)]);
		end
		settle();

		// Let the lock fall free, then nest a few levels with two waiters
		// queued, and unwind through both hand-overs to a free lock.
		while (lock_mirror.held)
			issue(rmwq_pkg::CMD_RELEASE, lock_mirror.holder);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'h3C);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'hC3);
		issue(rmwq_pkg::CMD_ACQUIRE, 8'h00);
		for (int k = 0; k < NEST_RUN; k++)
			issue(rmwq_pkg::CMD_ACQUIRE, 8'h3C);
		issue(rmwq_pkg::CMD_RELEASE, 8'hC3);
		for (int k = 0; k < NEST_RUN; k++)
			issue(rmwq_pkg::CMD_RELEASE, 8'h3C);
		issue(rmwq_pkg::CMD_RELEASE, 8'h3C);
		issue(rmwq_pkg::CMD_RELEASE, 8'hC3);
		issue(rmwq_pkg::CMD_RELEASE, 8'h00);
		settle();
		repeat (8) @(negedge clk);

		if (lock_mirror.failures == 0 && lock_mirror.pending() == 0) begin
			$display("recursive_mutex_wait_queue_core test passed");
		end else begin
			$display("recursive_mutex_wait_queue_core test failed");
		end
		$finish;
	end

endmodule
